// ===== rtl/core/aes128_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, constants and round functions for the AES-128 ECB core.
// ----------------------------------------------------------------------------
package aes128_pkg;

	localparam int NumRounds = 10;
	localparam int NumRk     = NumRounds + 1;

	// Configuration register indexes
	localparam logic [1:0] REG_KEY_HIGH = 2'd0;
	localparam logic [1:0] REG_KEY_LOW  = 2'd1;
	localparam logic [1:0] REG_DECRYPT  = 2'd2;

	localparam logic [7:0] GF_REDUCE = 8'h1b;

	typedef logic [127:0] block_t;
	typedef logic [7:0]   byte_t;

	// Flags that travel alongside the data through the cell row
	typedef struct packed {
		logic valid;
		logic decrypt;
	} ctl_t;

	localparam byte_t FWD_SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	localparam byte_t INV_SBOX [256] = '{
	8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
	8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
	8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
	8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
	8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
	8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
	8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
	8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
	8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
	8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
	8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
	8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
	8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
	8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
	8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
	8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

	localparam byte_t RCON [NumRk] = '{
	8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};

	function automatic byte_t xtime(input byte_t b);
		return {b[6:0], 1'b0} ^ (b[7] ? GF_REDUCE : 8'h00);
	endfunction

	// Byte i of the block sits at bits 127-8i..120-8i (column-major state)
	function automatic byte_t get_byte(input block_t s, input int i);
		return s[127 - 8*i -: 8];
	endfunction

	function automatic block_t sub_shift(input block_t s, input logic inv);
		block_t t;
		byte_t b;
		t = '0;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				if (inv) begin
					b = INV_SBOX[get_byte(s, 4*c + r)];
					t[127 - 8*(4*((c + r) % 4) + r) -: 8] = b;
				end else begin
					b = FWD_SBOX[get_byte(s, 4*((c + r) % 4) + r)];
					t[127 - 8*(4*c + r) -: 8] = b;
				end
			end
		end
		return t;
	endfunction

	function automatic block_t mix_cols(input block_t s, input logic inv);
		block_t t;
		byte_t a [4];
		byte_t x2 [4];
		byte_t x4 [4];
		byte_t x8 [4];
		byte_t m0, m1, m2, m3;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				a[r]  = get_byte(s, 4*c + r);
				x2[r] = xtime(a[r]);
				x4[r] = xtime(x2[r]);
				x8[r] = xtime(x4[r]);
			end
			for (int r = 0; r < 4; r++) begin
				if (inv) begin
					m0 = x8[r] ^ x4[r] ^ x2[r];
					m1 = x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4];
					m2 = x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4];
					m3 = x8[(r+3)%4] ^ a[(r+3)%4];
				end else begin
					m0 = x2[r];
					m1 = x2[(r+1)%4] ^ a[(r+1)%4];
					m2 = a[(r+2)%4];
					m3 = a[(r+3)%4];
				end
				t[127 - 8*(4*c + r) -: 8] = m0 ^ m1 ^ m2 ^ m3;
			end
		end
		return t;
	endfunction

	// One key-schedule step: next round key from the previous one
	function automatic block_t next_key(input block_t k, input int rnd);
		logic [31:0] w [4];
		logic [31:0] t;
		for (int i = 0; i < 4; i++) w[i] = k[127 - 32*i -: 32];
		t = {w[3][23:0], w[3][31:24]};
		t = {FWD_SBOX[t[31:24]], FWD_SBOX[t[23:16]], FWD_SBOX[t[15:8]], FWD_SBOX[t[7:0]]}
			^ {RCON[rnd], 24'h0};
		w[0] = w[0] ^ t;
		w[1] = w[1] ^ w[0];
		w[2] = w[2] ^ w[1];
		w[3] = w[3] ^ w[2];
		return {w[0], w[1], w[2], w[3]};
	endfunction

endpackage

// ===== rtl/core/aes128_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 stream interface
// Valid/ready channel carrying one 128-bit block as two 64-bit halves.
// ----------------------------------------------------------------------------
interface aes128_stream_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_high;
	logic [63:0] data_low;

	modport source (output valid, output data_high, output data_low, input ready);
	modport sink (input valid, input data_high, input data_low, output ready);
endinterface

// ===== rtl/core/aes128_key_sched.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 key schedule
// Sweeps the ten round-key steps in turn after a key write and holds
// all eleven round keys in registers.
// ----------------------------------------------------------------------------
module aes128_key_sched
	import aes128_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   load,
	input  block_t key,
	output block_t round_key [NumRk],
	output logic   busy
);

	localparam int CntW = $clog2(NumRk);

	block_t          rk_q [NumRk];
	logic [CntW-1:0] step_q;
	logic            busy_q;

	// Key write restarts the sweep; one round key per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= CntW'(1);
			busy_q <= 1'b1;
			rk_q   <= '{default: '0};
		end else if (load) begin
			rk_q[0] <= key;
			step_q  <= CntW'(1);
			busy_q  <= 1'b1;
		end else if (busy_q) begin
			rk_q[step_q] <= next_key(rk_q[step_q - CntW'(1)], int'(step_q));
			if (step_q == CntW'(NumRounds)) busy_q <= 1'b0;
			step_q <= step_q + CntW'(1);
		end
	end

	assign round_key = rk_q;
	assign busy      = busy_q;

endmodule

// ===== rtl/core/aes128_round_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 round cell
// One cipher round, registered. Performs an encrypt or decrypt round as the
// flag traveling with the transaction selects; final rounds skip MixColumns.
// ----------------------------------------------------------------------------
module aes128_round_cell
	import aes128_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   advance,
	input  logic   last,
	input  ctl_t   ctl_in,
	input  block_t data_in,
	input  block_t enc_key,
	input  block_t dec_key,
	output ctl_t   ctl_out,
	output block_t data_out
);

	ctl_t   ctl_q;
	block_t data_q;
	block_t ss, mixed;

	// Encrypt: SB,SR,MC,ARK. Decrypt: ISR,ISB,ARK,IMC.
	always_comb begin
		ss = sub_shift(data_in, ctl_in.decrypt);
		if (ctl_in.decrypt) begin
			mixed = last ? (ss ^ dec_key) : mix_cols(ss ^ dec_key, 1'b1);
		end else begin
			mixed = (last ? ss : mix_cols(ss, 1'b0)) ^ enc_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (advance) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) data_q <= mixed;
	end

	assign ctl_out  = ctl_q;
	assign data_out = data_q;

endmodule

// ===== rtl/core/aes128_block_cipher_core.sv =====
`timescale 1ns / 1ps
// Input to result: the whitening stage, then 10 round cells, each registered.
// Throughput: one block per cycle while the output is not stalled; the row of
// round cells advances together. A key write re-expands the schedule, during which
// no input is taken. Reset clears control state and expands the all-zero key.
// ----------------------------------------------------------------------------
// AES-128 ECB core
// Row of registered round cells with a key schedule and a config write port.
// ----------------------------------------------------------------------------
module aes128_block_cipher_core
	import aes128_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [63:0]      cfg_data,
	aes128_stream_if.sink    blk_in,
	aes128_stream_if.source  res_out
);

	logic [63:0] key_high_q, key_low_q;
	logic        decrypt_q;
	logic        key_load;
	logic        ks_busy;
	block_t      rk [NumRk];

	ctl_t   ctl   [NumRk];
	block_t data  [NumRk];
	ctl_t   ctl_s0;
	block_t data_s0;
	logic   advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			decrypt_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				REG_DECRYPT:  decrypt_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign key_load = cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);

	aes128_key_sched u_ks (
		.clk(clk), .arst_n(arst_n), .load(key_load),
		.key({cfg_index == REG_KEY_HIGH ? cfg_data : key_high_q,
			cfg_index == REG_KEY_LOW ? cfg_data : key_low_q}),
		.round_key(rk), .busy(ks_busy)
	);

	// Whole row moves when the output slot is free or empty
	assign advance      = !ctl[NumRounds].valid || res_out.ready;
	assign blk_in.ready = advance && !ks_busy;

	// Whitening stage: first AddRoundKey
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s0 <= '0;
		end else if (advance) begin
			ctl_s0 <= '{valid: blk_in.valid && !ks_busy, decrypt: decrypt_q};
		end
	end

	always_ff @(posedge clk) begin
		if (advance) data_s0 <= {blk_in.data_high, blk_in.data_low} ^
			(decrypt_q ? rk[NumRounds] : rk[0]);
	end

	assign ctl[0]  = ctl_s0;
	assign data[0] = data_s0;

	for (genvar i = 1; i < NumRk; i++) begin : g_cell
		aes128_round_cell u_cell (
			.clk(clk), .arst_n(arst_n), .advance(advance),
			.last(i == NumRounds),
			.ctl_in(ctl[i-1]), .data_in(data[i-1]),
			.enc_key(rk[i]), .dec_key(rk[NumRounds - i]),
			.ctl_out(ctl[i]), .data_out(data[i])
		);
	end

	assign res_out.valid     = ctl[NumRounds].valid;
	assign res_out.data_high = data[NumRounds][127:64];
	assign res_out.data_low  = data[NumRounds][63:0];

endmodule

// ===== rtl/core/aes128_core_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 core checker
// Port-level assertions, bound to the core top level.
// ----------------------------------------------------------------------------
module aes128_core_checker
	import aes128_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic [1:0]  cfg_index,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] out_high
);

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_high))
		else $error("result dropped or changed under stall");

	// Input is refused right after a key write while the schedule runs
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW) |=> !in_ready)
		else $error("input taken during key expansion");

	// Input is ready only when the output is empty or being taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!out_valid || out_ready))
		else $error("input ready while output stalled");

endmodule

bind aes128_block_cipher_core aes128_core_checker u_chk (
	.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
	.in_ready(blk_in.ready),
	.out_valid(res_out.valid), .out_ready(res_out.ready),
	.out_high(res_out.data_high)
);

// ===== bench/aes128_cipher_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 cipher checker
// Watches the config port and both block channels. Every accepted input
// transaction is run through a local AES-128 model under the current key and
// direction, and the result is queued. Each output transaction is compared
// with the oldest queued block.
// ----------------------------------------------------------------------------
module aes128_cipher_checker
	import aes128_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	aes128_stream_if    blk_in,
	aes128_stream_if    res_out,
	output int          mismatches,
	output int          pending
);

	typedef byte_t state_t [16];

	logic [63:0] key_hi, key_lo;
	logic        decrypt;
	logic [31:0] sched [44];
	block_t      expected_blocks [$];

	assign pending = expected_blocks.size();

	// Rebuild the 44-word schedule from key_hi/key_lo
	function automatic void build_schedule(input logic [63:0] hi, input logic [63:0] lo);
		logic [31:0] t;
		sched[0] = hi[63:32];
		sched[1] = hi[31:0];
		sched[2] = lo[63:32];
		sched[3] = lo[31:0];
		for (int i = 4; i < 44; i++) begin
			t = sched[i-1];
			if (i % 4 == 0) begin
				t = {t[23:0], t[31:24]};
				t = {FWD_SBOX[t[31:24]], FWD_SBOX[t[23:16]], FWD_SBOX[t[15:8]],
					FWD_SBOX[t[7:0]]} ^ {RCON[i/4], 24'h0};
			end
			sched[i] = sched[i-4] ^ t;
		end
	endfunction

	function automatic byte_t gmul(input byte_t a, input byte_t m);
		byte_t acc;
		acc = 8'h00;
		for (int b = 0; b < 4; b++) begin
			if (m[b]) acc = acc ^ a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return acc;
	endfunction

	function automatic state_t add_key(input state_t s, input int rnd);
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				s[4*c + r] = s[4*c + r] ^ sched[4*rnd + c][31 - 8*r -: 8];
		return s;
	endfunction

	// SubBytes and ShiftRows together (they commute)
	function automatic state_t subst_shift(input state_t s, input logic inv);
		state_t t;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				if (inv) t[4*((c + r) % 4) + r] = INV_SBOX[s[4*c + r]];
				else     t[4*c + r] = FWD_SBOX[s[4*((c + r) % 4) + r]];
		return t;
	endfunction

	function automatic state_t mix(input state_t s, input logic inv);
		state_t t;
		byte_t m0, m1, m2, m3;
		m0 = inv ? 8'h0e : 8'h02;
		m1 = inv ? 8'h0b : 8'h03;
		m2 = inv ? 8'h0d : 8'h01;
		m3 = inv ? 8'h09 : 8'h01;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[4*c + r] = gmul(s[4*c + r], m0) ^ gmul(s[4*c + (r+1)%4], m1)
					^ gmul(s[4*c + (r+2)%4], m2) ^ gmul(s[4*c + (r+3)%4], m3);
		return t;
	endfunction

	function automatic block_t aes_transform(input block_t blk, input logic inv);
		state_t s;
		block_t o;
		for (int i = 0; i < 16; i++) s[i] = blk[127 - 8*i -: 8];
		if (!inv) begin
			s = add_key(s, 0);
			for (int rnd = 1; rnd < 10; rnd++)
				s = add_key(mix(subst_shift(s, 1'b0), 1'b0), rnd);
			s = add_key(subst_shift(s, 1'b0), 10);
		end else begin
			s = add_key(s, 10);
			for (int rnd = 9; rnd > 0; rnd--)
				s = mix(add_key(subst_shift(s, 1'b1), rnd), 1'b1);
			s = add_key(subst_shift(s, 1'b1), 0);
		end
		for (int i = 0; i < 16; i++) o[127 - 8*i -: 8] = s[i];
		return o;
	endfunction

	// Monitor: config writes, input transactions, output transactions
	always @(posedge clk or negedge arst_n) begin
		block_t got, want;
		if (!arst_n) begin
			key_hi = '0;
			key_lo = '0;
			decrypt = 1'b0;
			build_schedule('0, '0);
			expected_blocks.delete();
			mismatches = 0;
		end else begin
			if (res_out.valid && res_out.ready) begin
				got = {res_out.data_high, res_out.data_low};
				if (expected_blocks.size() == 0) begin
					$error("unexpected result transaction %h", got);
					mismatches++;
				end else begin
					want = expected_blocks.pop_front();
					if (got[127:64] !== want[127:64]) begin
						$error("result_high: expected %h, actual %h", want[127:64], got[127:64]);
						mismatches++;
					end
					if (got[63:0] !== want[63:0]) begin
						$error("result_low: expected %h, actual %h", want[63:0], got[63:0]);
						mismatches++;
					end
				end
			end
			if (blk_in.valid && blk_in.ready)
				expected_blocks.push_back(
					aes_transform({blk_in.data_high, blk_in.data_low}, decrypt));
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY_HIGH: begin
						key_hi = cfg_data;
						build_schedule(key_hi, key_lo);
					end
					REG_KEY_LOW: begin
						key_lo = cfg_data;
						build_schedule(key_hi, key_lo);
					end
					REG_DECRYPT: decrypt = cfg_data[0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== bench/aes128_block_cipher_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 ECB core testbench
// Drives directed blocks (reset key, FIPS-197 vector, extreme patterns) and
// random blocks under a series of keys and directions, with varied source
// idling and sink stalling, including a long sink hold-off.
// ----------------------------------------------------------------------------
module aes128_block_cipher_core_test;
	import aes128_pkg::*;

	localparam int CycleLimit = 400000;
	localparam int LatencyPad = 20;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	int          mismatches;
	int          pending;
	int          cycles;
	int          send_idle;
	int          sink_stall;
	int          hold_token;
	int          hold_seen;
	int          hold_left;

	aes128_stream_if in_ch ();
	aes128_stream_if res_ch ();

	aes128_block_cipher_core DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .blk_in(in_ch), .res_out(res_ch)
	);

	aes128_cipher_checker scoreboard (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .blk_in(in_ch), .res_out(res_ch),
		.mismatches(mismatches), .pending(pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Timeout
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("aes128_block_cipher_core test failed");
			$finish;
		end
	end

	// Sink: random stalls, plus a long hold-off on request
	initial begin
		res_ch.ready = 1'b0;
		hold_seen = 0;
		hold_left = 0;
	end
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= 300;
			res_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= sink_stall);
		end
	end

	// One input transaction, with random idle cycles ahead of it
	task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			in_ch.data_high <= {$urandom, $urandom};
			in_ch.data_low <= {$urandom, $urandom};
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_high <= hi;
		in_ch.data_low <= lo;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Drain everything, then let the core settle before touching a register
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LatencyPad) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_patterns();
		send_block('0, '0);
		send_block('1, '1);
		send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
		send_block(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
	endtask

	task automatic random_phase(input int n, input int s_idle, input int r_stall,
			input bit long_hold);
		logic [63:0] kh, kl;
		case ($urandom_range(5))
			0: begin kh = '0; kl = '0; end
			1: begin kh = '1; kl = '1; end
			default: begin kh = {$urandom, $urandom}; kl = {$urandom, $urandom}; end
		endcase
		write_reg(REG_KEY_HIGH, kh);
		write_reg(REG_KEY_LOW, kl);
		write_reg(REG_DECRYPT, {$urandom, $urandom});
		send_idle = s_idle;
		sink_stall = r_stall;
		for (int i = 0; i < n; i++) begin
			if (long_hold && i == 10) hold_token++;
			// pause once mid-phase until the pipeline is empty
			if (i == n / 2) drain();
			send_block({$urandom, $urandom}, {$urandom, $urandom});
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_KEY_HIGH;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data_high = '0;
		in_ch.data_low = '0;
		send_idle = 0;
		sink_stall = 0;
		hold_token = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset key, encrypt then decrypt (upper bits set, bit 0 kept)
		send_patterns();
		write_reg(REG_DECRYPT, 64'hffff_ffff_ffff_ffff);
		send_patterns();

		// FIPS-197 key; mode write with bit 0 clear but upper bits set
		write_reg(REG_KEY_HIGH, 64'h0001_0203_0405_0607);
		write_reg(REG_KEY_LOW, 64'h0809_0a0b_0c0d_0e0f);
		write_reg(REG_DECRYPT, 64'hffff_ffff_ffff_fffe);
		send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
		// unused register index must not disturb anything
		write_reg(2'd3, 64'hdead_beef_0123_4567);
		send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
		write_reg(REG_DECRYPT, 64'd1);
		send_block(64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a);
		// mode change alone keeps the schedule
		write_reg(REG_DECRYPT, 64'd0);
		send_patterns();

		// All-ones key both ways
		write_reg(REG_KEY_HIGH, '1);
		write_reg(REG_KEY_LOW, '1);
		send_patterns();
		write_reg(REG_DECRYPT, 64'd1);
		send_patterns();

		random_phase(100, 0, 0, 1'b0);
		random_phase(100, 0, 0, 1'b1);
		random_phase(100, 84, 0, 1'b0);
		random_phase(100, 0, 84, 1'b0);
		random_phase(100, 10, 10, 1'b0);
		random_phase(100, 84, 0, 1'b0);
		random_phase(100, 0, 84, 1'b0);
		random_phase(100, 10, 10, 1'b1);

		drain();
		if (mismatches == 0)
			$display("aes128_block_cipher_core test passed");
		else
			$display("aes128_block_cipher_core test failed");
		$finish;
	end

endmodule

// ===== aes128_block_cipher_core.f =====
rtl/core/aes128_pkg.sv
rtl/core/aes128_stream_if.sv
rtl/core/aes128_key_sched.sv
rtl/core/aes128_round_cell.sv
rtl/core/aes128_block_cipher_core.sv
rtl/core/aes128_core_checker.sv
bench/aes128_cipher_checker.sv
bench/aes128_block_cipher_core_test.sv
